@@ design/pli_pkg.sv @@
`timescale 1ns / 1ps

package pli_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int PC_W        = 7;
  localparam int DIV_STEPS   = 32;
  localparam int DIV_CW      = $clog2(DIV_STEPS);

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_EVAL   = 2'd2;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_RANGE = 3'd1;
  localparam logic [2:0] ST_EMPTY = 3'd2;
  localparam logic [2:0] ST_DUP   = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] x_arg;
    logic signed [31:0] y_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
    logic signed [31:0] y_maximum;
    logic signed [31:0] y_minimum;
    logic [PC_W-1:0]    point_count;
  } out_t;

  typedef struct packed {
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic signed [31:0] wr_x;
    logic signed [31:0] wr_y;
    logic [IDX_W-1:0]   rd_addr;
  } tbl_req_t;

endpackage

@@ design/pli_table.sv @@
`timescale 1ns / 1ps

module pli_table (
  input  logic                clk,
  input  pli_pkg::tbl_req_t   req,
  output logic signed [31:0]  rd_x,
  output logic signed [31:0]  rd_y
);

  logic signed [31:0] x_mem [pli_pkg::TABLE_DEPTH];
  logic signed [31:0] y_mem [pli_pkg::TABLE_DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      x_mem[req.wr_addr] <= req.wr_x;
      y_mem[req.wr_addr] <= req.wr_y;
    end
    rd_x <= x_mem[req.rd_addr];
    rd_y <= y_mem[req.rd_addr];
  end

endmodule

@@ design/pli_divider.sv @@
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle; needs dividend[63:32] < divisor
module pli_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic [31:0]             rem;
  logic [31:0]             dl;
  logic [31:0]             dsr;
  logic [pli_pkg::DIV_CW-1:0] cnt;
  logic                    busy;
  logic [32:0]             trial;
  logic                    take;

  assign trial    = {rem, dl[31]};
  assign take     = trial >= {1'b0, dsr};
  assign quotient = dl;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= pli_pkg::DIV_CW'(pli_pkg::DIV_STEPS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[63:32];
      dl  <= dividend[31:0];
      dsr <= divisor;
    end else if (busy) begin
      rem <= take ? 32'(trial - {1'b0, dsr}) : trial[31:0];
      dl  <= {dl[30:0], take};
    end
  end

endmodule

@@ design/piecewise_linear_interpolator_unit.sv @@
`timescale 1ns / 1ps

// Channel  Dir  Handshake              Payload
// in       in   in_valid / in_ready    pli_pkg::in_t  (func, x_arg, y_value)
// out      out  out_valid / out_ready  pli_pkg::out_t (value, status, extremes, count)
//
// One transaction at a time; in_ready is high only when the sequencer is idle.
// Clear goes straight to the result. Insert runs a binary search of k steps
// (about log2(n)) for the first x >= arg, then shifts the entries from pos upward
// entry by entry through the table and writes the new point; evaluate runs the
// search, then waits on the 32-step serial divider.
// Early exits (empty, out of range, top x) skip the search.
// Synchronous reset empties the table (count and extremes to zero).
// A result held on a stalled output blocks only the next completion.

module piecewise_linear_interpolator_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  pli_pkg::in_t  in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output pli_pkg::out_t out_item
);

  localparam int S_W = 4;
  localparam logic [S_W-1:0] S_IDLE  = 4'd0;
  localparam logic [S_W-1:0] S_SRCH  = 4'd1;
  localparam logic [S_W-1:0] S_CMP   = 4'd2;
  localparam logic [S_W-1:0] S_IDUP  = 4'd3;
  localparam logic [S_W-1:0] S_ICHK  = 4'd4;
  localparam logic [S_W-1:0] S_SHIFT = 4'd5;
  localparam logic [S_W-1:0] S_SHWR  = 4'd6;
  localparam logic [S_W-1:0] S_ELO   = 4'd7;
  localparam logic [S_W-1:0] S_EHI   = 4'd8;
  localparam logic [S_W-1:0] S_EP0   = 4'd9;
  localparam logic [S_W-1:0] S_EP1   = 4'd10;
  localparam logic [S_W-1:0] S_EMUL  = 4'd11;
  localparam logic [S_W-1:0] S_EDIV  = 4'd12;
  localparam logic [S_W-1:0] S_FIN   = 4'd13;

  localparam int CW = pli_pkg::CNT_W;
  localparam int IW = pli_pkg::IDX_W;

  logic [S_W-1:0]     state;
  logic [CW-1:0]      count;
  logic signed [31:0] y_max;
  logic signed [31:0] y_min;
  logic               is_eval;
  logic signed [31:0] xa;
  logic signed [31:0] ya;
  logic [CW-1:0]      lo;
  logic [CW-1:0]      hi;
  logic [CW-1:0]      idx;
  logic signed [31:0] x0;
  logic signed [31:0] y0;
  logic [31:0]        mag;
  logic [31:0]        off;
  logic [31:0]        gap;
  logic               neg;
  logic signed [31:0] res_value;
  logic [2:0]         res_status;

  pli_pkg::tbl_req_t  req;
  logic signed [31:0] rd_x;
  logic signed [31:0] rd_y;
  logic               div_done;
  logic [31:0]        quot;
  logic [CW:0]        mid_sum;
  logic [CW-1:0]      mid;
  logic               go_right;
  logic signed [32:0] dy;
  logic signed [33:0] sum;
  logic signed [31:0] sat;

  pli_table u_table (
    .clk  (clk),
    .req  (req),
    .rd_x (rd_x),
    .rd_y (rd_y)
  );

  pli_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_EMUL),
    .dividend (mag * off),
    .divisor  (gap),
    .done     (div_done),
    .quotient (quot)
  );

  assign in_ready = (state == S_IDLE);
  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid      = mid_sum[CW:1];
  // insert looks for the first x >= arg, evaluate for the first x > arg
  assign go_right = is_eval ? (rd_x <= xa) : (rd_x < xa);
  assign dy       = {rd_y[31], rd_y} - {y0[31], y0};
  assign sum      = neg ? ({{2{y0[31]}}, y0} - {2'b00, quot})
                        : ({{2{y0[31]}}, y0} + {2'b00, quot});

  always_comb begin
    if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
      sat = sum[31:0];
    end else if (sum[33]) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = 32'sh7fff_ffff;
    end
  end

  // table port: one read address per cycle, data seen in the following state
  always_comb begin
    req         = '0;
    req.wr_x    = rd_x;
    req.wr_y    = rd_y;
    req.wr_addr = idx[IW-1:0];
    unique case (state)
      S_IDLE:  req.rd_addr = '0;
      S_SRCH:  req.rd_addr = mid[IW-1:0];
      S_ICHK,
      S_SHIFT: req.rd_addr = IW'(idx - 1'b1);
      S_ELO:   req.rd_addr = IW'(count - 1'b1);
      default: req.rd_addr = lo[IW-1:0];
    endcase
    if (state == S_SRCH && lo >= hi) begin
      req.rd_addr = is_eval ? IW'(lo - 1'b1) : lo[IW-1:0];
    end
    if (state == S_EP0) begin
      req.rd_addr = lo[IW-1:0];
    end
    if (state == S_SHWR) begin
      req.wr_en = 1'b1;
    end
    if (state == S_SHIFT && idx <= lo) begin
      req.wr_en   = 1'b1;
      req.wr_addr = lo[IW-1:0];
      req.wr_x    = xa;
      req.wr_y    = ya;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      y_max     <= '0;
      y_min     <= '0;
      out_valid <= 1'b0;
    end else begin
      // a new result in S_FIN takes over the output register
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            res_value  <= '0;
            res_status <= pli_pkg::ST_OK;
            is_eval    <= (in_item.func == pli_pkg::FUNC_EVAL);
            xa         <= in_item.x_arg;
            ya         <= in_item.y_value;
            lo         <= '0;
            hi         <= count;
            unique case (in_item.func)
              pli_pkg::FUNC_CLEAR: begin
                count <= '0;
                y_max <= '0;
                y_min <= '0;
                state <= S_FIN;
              end
              pli_pkg::FUNC_INSERT: state <= S_SRCH;
              pli_pkg::FUNC_EVAL: begin
                if (count == '0) begin
                  res_status <= pli_pkg::ST_EMPTY;
                  state      <= S_FIN;
                end else begin
                  state <= S_ELO;
                end
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_ELO: begin
          if (xa < rd_x) begin
            res_status <= pli_pkg::ST_RANGE;
            state      <= S_FIN;
          end else begin
            state <= S_EHI;
          end
        end
        S_EHI: begin
          if (xa > rd_x) begin
            res_status <= pli_pkg::ST_RANGE;
            state      <= S_FIN;
          end else if (xa == rd_x) begin
            res_value <= rd_y;
            state     <= S_FIN;
          end else begin
            hi    <= CW'(count - 1'b1);
            state <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (lo < hi) begin
            state <= S_CMP;
          end else if (is_eval) begin
            state <= S_EP0;
          end else if (lo < count) begin
            state <= S_IDUP;
          end else begin
            state <= S_ICHK;
          end
        end
        S_CMP: begin
          if (go_right) begin
            lo <= CW'(mid + 1'b1);
          end else begin
            hi <= mid;
          end
          state <= S_SRCH;
        end
        S_IDUP: begin
          if (rd_x == xa) begin
            res_status <= pli_pkg::ST_DUP;
            state      <= S_FIN;
          end else begin
            state <= S_ICHK;
          end
        end
        S_ICHK: begin
          if (count >= CW'(pli_pkg::TABLE_DEPTH)) begin
            res_status <= pli_pkg::ST_FULL;
            state      <= S_FIN;
          end else begin
            idx   <= count;
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (idx > lo) begin
            state <= S_SHWR;
          end else begin
            if (count == '0) begin
              y_max <= ya;
              y_min <= ya;
            end else begin
              if (ya > y_max) y_max <= ya;
              if (ya < y_min) y_min <= ya;
            end
            count <= CW'(count + 1'b1);
            state <= S_FIN;
          end
        end
        S_SHWR: begin
          idx   <= CW'(idx - 1'b1);
          state <= S_SHIFT;
        end
        S_EP0: begin
          x0    <= rd_x;
          y0    <= rd_y;
          state <= S_EP1;
        end
        S_EP1: begin
          neg   <= dy[32];
          mag   <= dy[32] ? 32'(-dy) : dy[31:0];
          off   <= 32'(xa - x0);
          gap   <= 32'(rd_x - x0);
          state <= S_EMUL;
        end
        S_EMUL: state <= S_EDIV;
        S_EDIV: begin
          if (div_done) begin
            res_value <= sat;
            state     <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid            <= 1'b1;
            out_item.value       <= res_value;
            out_item.status      <= res_status;
            out_item.y_maximum   <= y_max;
            out_item.y_minimum   <= y_min;
            out_item.point_count <= pli_pkg::PC_W'(count);
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
